[sv/sequenced_ring_fifo_core_macros.svh]
// ----------------------------------------------------------------------------
// Sequenced ring FIFO assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SEQUENCED_RING_FIFO_CORE_MACROS_SVH
`define SEQUENCED_RING_FIFO_CORE_MACROS_SVH

// same-cycle implication
`define SRF_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequenced_ring_fifo_core: assertion failed");

// next-cycle implication
`define SRF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequenced_ring_fifo_core: assertion failed");

`endif

[sv/srf_pkg.sv]
// ----------------------------------------------------------------------------
// Sequenced ring FIFO package
// Field widths, operation and register codes, and the control types shared by
// the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package srf_pkg;

    localparam int OPC_W      = 3;
    localparam int ENTRY_IO_W = 64;
    localparam int POS_W      = 32;
    localparam int FILL_W     = 9;
    localparam int CAP_REG_W  = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int CAP_RST    = 256;

    typedef enum logic [OPC_W-1:0] {
        OP_PUT      = 3'd0,
        OP_GET      = 3'd1,
        OP_COUNT    = 3'd2,
        OP_PEEK_REL = 3'd3,
        OP_PEEK_ABS = 3'd4
    } t_srf_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAPACITY  = 2'd0,
        REG_START_SEQ = 2'd1
    } t_srf_reg;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_MEM,
        SRC_ECHO
    } t_srf_src;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } t_srf_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_srf_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic order_ok;
    } t_srf_status;

endpackage

[sv/srf_channels.sv]
// ----------------------------------------------------------------------------
// Sequenced ring FIFO channels
// Valid/ready channel interfaces for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface srf_req_if;
    logic                              valid;
    logic                              ready;
    logic [srf_pkg::OPC_W-1:0]         opcode;
    logic [srf_pkg::ENTRY_IO_W-1:0]    entry_in;
    logic [srf_pkg::POS_W-1:0]         position;

    modport source (output valid, output opcode, output entry_in, output position,
                    input ready);
    modport sink   (input valid, input opcode, input entry_in, input position,
                    output ready);
endinterface

interface srf_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              ok;
    logic [srf_pkg::ENTRY_IO_W-1:0]    entry_out;
    logic [srf_pkg::FILL_W-1:0]        fill_count;

    modport source (output valid, output ok, output entry_out, output fill_count,
                    input ready);
    modport sink   (input valid, input ok, input entry_out, input fill_count,
                    output ready);
endinterface

interface srf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [srf_pkg::CFG_IDX_W-1:0]     index;
    logic [srf_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/srf_ctrl.sv]
// ----------------------------------------------------------------------------
// Sequenced ring FIFO controller
// Sequences capture, slot access and response load, and owns response valid.
// ----------------------------------------------------------------------------
module srf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_rsp_ready,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    output srf_pkg::t_srf_cmd o_cmd
);

    srf_pkg::t_srf_state r_state, n_state;
    logic                r_rsp_valid, n_rsp_valid;
    logic                w_out_free;

    assign w_out_free = !r_rsp_valid || i_rsp_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srf_pkg::ST_IDLE: begin
                if (i_req_valid) n_state = srf_pkg::ST_EXEC;
            end
            srf_pkg::ST_EXEC: begin
                n_state = srf_pkg::ST_LOAD;
            end
            srf_pkg::ST_LOAD: begin
                if (w_out_free) n_state = srf_pkg::ST_IDLE;
            end
            default: begin
                n_state = srf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            srf_pkg::ST_IDLE: begin
                o_req_ready   = i_rst_n;
                o_cmd.capture = i_req_valid && i_rst_n;
            end
            srf_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            srf_pkg::ST_LOAD: begin
                o_cmd.load = w_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        priority if (o_cmd.load) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end else begin
            n_rsp_valid = r_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srf_pkg::ST_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

[sv/srf_datapath.sv]
// ----------------------------------------------------------------------------
// Sequenced ring FIFO datapath
// Ring indices, base sequence, slot memory, window checks and response register.
// ----------------------------------------------------------------------------
module srf_datapath #(
    parameter int DEPTH   = 256,
    parameter int ENTRY_W = 64,
    parameter int SEQ_W   = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  srf_pkg::t_srf_cmd                  i_cmd,
    input  logic                               i_cfg_we,
    input  logic [srf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [srf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [srf_pkg::OPC_W-1:0]          i_opcode,
    input  logic [srf_pkg::ENTRY_IO_W-1:0]     i_entry_in,
    input  logic [srf_pkg::POS_W-1:0]          i_position,
    output srf_pkg::t_srf_status               o_status,
    output logic                               o_ok,
    output logic [srf_pkg::ENTRY_IO_W-1:0]     o_entry_out,
    output logic [srf_pkg::FILL_W-1:0]         o_fill_count
);

    localparam int IW      = $clog2(DEPTH);
    localparam int UW      = IW + 1;
    localparam int PW      = (srf_pkg::POS_W > UW) ? srf_pkg::POS_W : UW;
    localparam int RW      = (SEQ_W > UW) ? SEQ_W : UW;
    localparam int CAP_RST = (srf_pkg::CAP_RST > DEPTH) ? DEPTH : srf_pkg::CAP_RST;

    logic [IW-1:0]             r_ri;
    logic [IW-1:0]             r_wi;
    logic                      r_wrapped;
    logic [SEQ_W-1:0]          r_base;
    logic [UW-1:0]             r_cap;
    logic [srf_pkg::CFG_DATA_W-1:0] r_start;

    srf_pkg::t_srf_op          r_op;
    logic [ENTRY_W-1:0]        r_word;
    logic [srf_pkg::POS_W-1:0] r_pos;

    logic                      r_res_ok;
    srf_pkg::t_srf_src         r_src;
    logic [UW-1:0]             r_fill_after;
    logic [ENTRY_W-1:0]        r_rd;

    logic [ENTRY_W-1:0]        r_mem [DEPTH];

    logic                      r_out_ok;
    logic [srf_pkg::ENTRY_IO_W-1:0] r_out_entry;
    logic [srf_pkg::FILL_W-1:0]     r_out_fill;

    logic [UW-1:0]             w_cap_new;
    logic [srf_pkg::CAP_REG_W-1:0] w_cap_field;
    logic [UW-1:0]             w_ub;
    logic [UW-1:0]             w_fill;
    logic [UW-1:0]             w_ri_inc;
    logic [UW-1:0]             w_wi_inc;
    logic                      w_ri_hit;
    logic                      w_wi_hit;
    logic [UW-1:0]             w_rel_sum;
    logic [IW-1:0]             w_rel_idx;
    logic                      w_rel_hit;
    logic [SEQ_W-1:0]          w_rel_seq;
    logic [UW-1:0]             w_abs_off;
    logic [IW-1:0]             w_abs_idx;
    logic                      w_abs_hit;
    logic                      w_put_ok;
    logic                      w_get_ok;
    logic                      w_ok;
    srf_pkg::t_srf_src         w_src;
    logic [IW-1:0]             w_rd_addr;
    logic [UW-1:0]             w_fill_after;
    logic [srf_pkg::ENTRY_IO_W-1:0] w_entry;

    // clamp capacity into 1..DEPTH
    assign w_cap_field = i_cfg_data[srf_pkg::CAP_REG_W-1:0];
    always_comb begin
        priority if (w_cap_field == '0) begin
            w_cap_new = UW'(1);
        end else if (32'(w_cap_field) > 32'(DEPTH)) begin
            w_cap_new = UW'(DEPTH);
        end else begin
            w_cap_new = UW'(w_cap_field);
        end
    end

    assign w_ub     = {1'b0, r_wi} + (r_wrapped ? r_cap : '0);
    assign w_fill   = w_ub - {1'b0, r_ri};
    assign w_ri_inc = {1'b0, r_ri} + UW'(1);
    assign w_wi_inc = {1'b0, r_wi} + UW'(1);
    assign w_ri_hit = w_ri_inc >= r_cap;
    assign w_wi_hit = w_wi_inc >= r_cap;

    assign w_rel_hit = PW'(r_pos) < PW'(w_fill);
    assign w_rel_sum = {1'b0, r_ri} + UW'(r_pos);
    always_comb begin
        if (w_rel_sum >= r_cap) begin
            w_rel_idx = IW'(w_rel_sum - r_cap);
        end else begin
            w_rel_idx = IW'(w_rel_sum);
        end
    end

    assign w_rel_seq = SEQ_W'(r_pos) - r_base;
    assign w_abs_hit = (RW'(w_rel_seq) >= RW'(r_ri)) && (RW'(w_rel_seq) < RW'(w_ub));
    assign w_abs_off = UW'(w_rel_seq);
    always_comb begin
        if (w_abs_off >= r_cap) begin
            w_abs_idx = IW'(w_abs_off - r_cap);
        end else begin
            w_abs_idx = IW'(w_abs_off);
        end
    end

    always_comb begin
        w_put_ok  = 1'b0;
        w_get_ok  = 1'b0;
        w_ok      = 1'b0;
        w_src     = srf_pkg::SRC_ZERO;
        w_rd_addr = r_ri;
        unique case (r_op)
            srf_pkg::OP_PUT: begin
                w_put_ok = w_fill < r_cap;
                w_ok     = w_put_ok;
                w_src    = srf_pkg::SRC_ECHO;
            end
            srf_pkg::OP_GET: begin
                w_get_ok = w_fill != '0;
                w_ok     = w_get_ok;
                w_src    = srf_pkg::SRC_MEM;
            end
            srf_pkg::OP_COUNT: begin
                w_ok = 1'b1;
            end
            srf_pkg::OP_PEEK_REL: begin
                w_ok      = w_rel_hit;
                w_src     = srf_pkg::SRC_MEM;
                w_rd_addr = w_rel_idx;
            end
            srf_pkg::OP_PEEK_ABS: begin
                w_ok      = w_abs_hit;
                w_src     = srf_pkg::SRC_MEM;
                w_rd_addr = w_abs_idx;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        priority if (w_put_ok) begin
            w_fill_after = w_fill + UW'(1);
        end else if (w_get_ok) begin
            w_fill_after = w_fill - UW'(1);
        end else begin
            w_fill_after = w_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ri      <= '0;
            r_wi      <= '0;
            r_wrapped <= 1'b0;
            r_base    <= '0;
            r_cap     <= UW'(CAP_RST);
            r_start   <= '0;
        end else if (i_cfg_we) begin
            unique case (srf_pkg::t_srf_reg'(i_cfg_index))
                srf_pkg::REG_CAPACITY: begin
                    r_cap     <= w_cap_new;
                    r_ri      <= '0;
                    r_wi      <= '0;
                    r_wrapped <= 1'b0;
                    r_base    <= SEQ_W'(r_start);
                end
                srf_pkg::REG_START_SEQ: begin
                    r_start   <= i_cfg_data;
                    r_ri      <= '0;
                    r_wi      <= '0;
                    r_wrapped <= 1'b0;
                    r_base    <= SEQ_W'(i_cfg_data);
                end
                default: begin
                    r_start <= r_start;
                end
            endcase
        end else if (i_cmd.exec) begin
            if (w_put_ok) begin
                if (w_wi_hit) begin
                    r_wi      <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_wi <= IW'(w_wi_inc);
                end
            end
            if (w_get_ok) begin
                if (w_ri_hit) begin
                    r_ri      <= '0;
                    r_wrapped <= 1'b0;
                    r_base    <= r_base + SEQ_W'(r_cap);
                end else begin
                    r_ri <= IW'(w_ri_inc);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= srf_pkg::t_srf_op'(i_opcode);
            r_word <= ENTRY_W'(i_entry_in);
            r_pos  <= i_position;
        end
        if (i_cmd.exec) begin
            r_res_ok     <= w_ok;
            r_src        <= w_src;
            r_fill_after <= w_fill_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_put_ok) begin
            r_mem[r_wi] <= r_word;
        end
        if (i_cmd.exec) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    always_comb begin
        w_entry = '0;
        unique case (r_src)
            srf_pkg::SRC_MEM:  w_entry = srf_pkg::ENTRY_IO_W'(r_rd);
            srf_pkg::SRC_ECHO: w_entry = srf_pkg::ENTRY_IO_W'(r_word);
            srf_pkg::SRC_ZERO: w_entry = '0;
            default:           w_entry = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_ok    <= r_res_ok;
            r_out_entry <= r_res_ok ? w_entry : '0;
            r_out_fill  <= srf_pkg::FILL_W'(r_fill_after);
        end
    end

    assign o_ok         = r_out_ok;
    assign o_entry_out  = r_out_entry;
    assign o_fill_count = r_out_fill;

    assign o_status.full     = w_fill == r_cap;
    assign o_status.empty    = w_fill == '0;
    assign o_status.order_ok = r_wrapped ? (r_wi <= r_ri) : (r_wi >= r_ri);

endmodule

[sv/sequenced_ring_fifo_core.sv]
// ----------------------------------------------------------------------------
// Sequenced ring FIFO core
// Ring FIFO of entry words with put, get, count and relative or absolute peek.
// ----------------------------------------------------------------------------
// Each request is captured, then runs the window checks with the slot write
// of a put and the slot read of the memory, whose read data is registered,
// then loads the response register once it is free. The next request is
// accepted in the cycle after that load, so a new request waits until the last
// one has loaded its response; a response may wait in its register while the
// next request is in flight. A write to either configuration register clears
// the indices and the wrap flag and sets the base sequence to the start
// sequence; slot contents stay. No clearing pass runs after reset.
module sequenced_ring_fifo_core #(
    parameter int DEPTH   = 256,
    parameter int ENTRY_W = 64,
    parameter int SEQ_W   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srf_req_if.sink     i_req,
    srf_rsp_if.source   o_rsp,
    srf_cfg_if.sink     i_cfg
);

    `include "sequenced_ring_fifo_core_macros.svh"

    srf_pkg::t_srf_cmd    w_cmd;
    srf_pkg::t_srf_status w_status;
    logic                 w_cfg_we;

    assign i_cfg.ready = i_rst_n;
    assign w_cfg_we    = i_cfg.valid && i_cfg.ready;

    srf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (w_cmd)
    );

    srf_datapath #(
        .DEPTH   (DEPTH),
        .ENTRY_W (ENTRY_W),
        .SEQ_W   (SEQ_W)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cfg_we     (w_cfg_we),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_opcode     (i_req.opcode),
        .i_entry_in   (i_req.entry_in),
        .i_position   (i_req.position),
        .o_status     (w_status),
        .o_ok         (o_rsp.ok),
        .o_entry_out  (o_rsp.entry_out),
        .o_fill_count (o_rsp.fill_count)
    );

    `SRF_ASSERT_IMPL(a_cmd_exclusive, i_clk, i_rst_n, 1'b1, $onehot0(w_cmd))
    `SRF_ASSERT_NEXT(a_exec_after_capture, i_clk, i_rst_n, w_cmd.capture, w_cmd.exec)
    `SRF_ASSERT_IMPL(a_load_when_free, i_clk, i_rst_n, w_cmd.load, !o_rsp.valid || o_rsp.ready)
    `SRF_ASSERT_IMPL(a_index_order, i_clk, i_rst_n, 1'b1, w_status.order_ok)
    `SRF_ASSERT_IMPL(a_full_not_empty, i_clk, i_rst_n, w_status.full, !w_status.empty)

endmodule
